/* design/bdq_pkg.sv */
// Shared action and status codes and controller/datapath command types.
package bdq_pkg;
    localparam logic [2:0] ACT_ADD_FRONT  = 3'd0;
    localparam logic [2:0] ACT_ADD_BACK   = 3'd1;
    localparam logic [2:0] ACT_TAKE_FRONT = 3'd2;
    localparam logic [2:0] ACT_TAKE_BACK  = 3'd3;
    localparam logic [2:0] ACT_REMOVE     = 3'd4;
    localparam logic [2:0] ACT_FIND       = 3'd5;
    localparam logic [2:0] ACT_CLEAR      = 3'd6;
    localparam logic [2:0] ACT_NOP        = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic       exec;
        logic [2:0] action;
    } t_cmd;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
    } t_sts;
endpackage

/* design/bdq_datapath.sv */
// Shifting cell chain holding the ordered list, with parallel compare.
module bdq_datapath
    import bdq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [DATA_WIDTH-1:0] i_value,
    output t_sts                  o_sts,
    output logic [CW-1:0]         o_count,
    output logic [DATA_WIDTH-1:0] o_front,
    output logic [DATA_WIDTH-1:0] o_back
);
    localparam int IW = $clog2(CAPACITY);

    logic [DATA_WIDTH-1:0] r_cell [CAPACITY];
    logic [DATA_WIDTH-1:0] n_cell [CAPACITY];
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CAPACITY-1:0]   w_match, w_first, w_after;
    logic                  w_full, w_empty, w_any;

    assign w_full  = (r_cnt == CW'(CAPACITY));
    assign w_empty = (r_cnt == '0);

    always_comb begin
        for (int i = 0; i < CAPACITY; i++)
            w_match[i] = (CW'(i) < r_cnt) && (r_cell[i] == i_value);
    end

    // one-hot first match, and mask of positions at or after it
    assign w_first = w_match & (~w_match + 1'b1);
    assign w_after = ~(w_first - 1'b1) & {CAPACITY{w_any}};
    assign w_any   = |w_match;

    always_comb begin
        n_cell = r_cell;
        n_cnt  = r_cnt;
        o_sts  = '{hit: 1'b0, status: ST_OK};
        if (i_cmd.exec) begin
            case (i_cmd.action)
                ACT_ADD_FRONT, ACT_ADD_BACK: begin
                    if (w_full) begin
                        o_sts.status = ST_FULL;
                    end else begin
                        o_sts.hit = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                        if (i_cmd.action == ACT_ADD_FRONT) begin
                            for (int i = 1; i < CAPACITY; i++)
                                n_cell[i] = r_cell[i-1];
                            n_cell[0] = i_value;
                        end else begin
                            n_cell[r_cnt[IW-1:0]] = i_value;
                        end
                    end
                end
                ACT_TAKE_FRONT, ACT_TAKE_BACK: begin
                    if (w_empty) begin
                        o_sts.status = ST_EMPTY;
                    end else begin
                        o_sts.hit = 1'b1;
                        n_cnt = r_cnt - 1'b1;
                        if (i_cmd.action == ACT_TAKE_FRONT) begin
                            for (int i = 0; i < CAPACITY - 1; i++)
                                n_cell[i] = r_cell[i+1];
                        end
                    end
                end
                ACT_REMOVE: begin
                    if (w_any) begin
                        o_sts.hit = 1'b1;
                        n_cnt = r_cnt - 1'b1;
                        for (int i = 0; i < CAPACITY - 1; i++)
                            if (w_after[i]) n_cell[i] = r_cell[i+1];
                    end
                end
                ACT_FIND:  o_sts.hit = w_any;
                ACT_CLEAR: n_cnt = '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (!i_rst_n) r_cnt <= '0;
        else          r_cnt <= n_cnt;
    end

    logic [CW-1:0] w_last;
    assign w_last  = n_cnt - 1'b1;
    assign o_count = n_cnt;
    assign o_front = (n_cnt == '0) ? '0 : n_cell[0];
    assign o_back  = (n_cnt == '0) ? '0 : n_cell[w_last[IW-1:0]];
endmodule

/* design/bdq_ctrl.sv */
// Handshake controller: accepts a transaction and holds its result until taken.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_action,
    input  logic       i_out_ready,
    output logic       o_ready,
    output logic       o_valid,
    output t_cmd       o_cmd,
    output logic       o_load
);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic r_state, n_state;

    // accept when output slot is empty or being emptied this cycle
    assign o_ready    = (r_state == ST_IDLE) || i_out_ready;
    assign o_load     = i_valid && o_ready;
    assign o_cmd.exec   = o_load;
    assign o_cmd.action = i_action;
    assign o_valid    = (r_state == ST_HOLD);

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = o_load ? ST_HOLD : ST_IDLE;
            ST_HOLD: n_state = (i_out_ready && !o_load) ? ST_IDLE : ST_HOLD;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end
endmodule

/* design/bounded_deque_with_remove.sv */
// Top level: bounded deque with search and delete.
// The result is registered and is valid in the cycle after the transaction is accepted.
// One action per cycle while results are taken without stall; the whole cell chain updates at once.
// A new transaction is taken in the same cycle the previous result is taken.
// Reset (i_rst_n low, synchronous): list empty, no result pending.
// Cell contents are not reset; only entries below the count are ever shown.
module bounded_deque_with_remove
    import bdq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [1:0]  o_status,
    output logic [4:0]  o_count,
    output logic        o_is_empty,
    output logic [31:0] o_front_word,
    output logic [31:0] o_back_word
);
    localparam int CW = $clog2(CAPACITY + 1);

    t_cmd                  w_cmd;
    t_sts                  w_sts;
    logic                  w_load;
    logic [CW-1:0]         w_count;
    logic [DATA_WIDTH-1:0] w_front, w_back;

    bdq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_action(i_action),
        .i_out_ready(i_ready), .o_ready(o_ready), .o_valid(o_valid),
        .o_cmd(w_cmd), .o_load(w_load)
    );

    bdq_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_value(DATA_WIDTH'(i_value)), .o_sts(w_sts), .o_count(w_count),
        .o_front(w_front), .o_back(w_back)
    );

    logic [CW-1:0]         r_count;
    logic [DATA_WIDTH-1:0] r_front, r_back;
    t_sts                  r_sts;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sts   <= w_sts;
            r_count <= w_count;
            r_front <= w_front;
            r_back  <= w_back;
        end
    end

    assign o_hit        = r_sts.hit;
    assign o_status     = r_sts.status;
    assign o_count      = 5'(r_count);
    assign o_is_empty   = (r_count == '0);
    assign o_front_word = 32'(r_front);
    assign o_back_word  = 32'(r_back);
endmodule

/* design/bdq_checker.sv */
// Port-level checker for the deque, bound to the top level.
module bdq_checker
    import bdq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_hit,
    input logic [1:0]  o_status,
    input logic [4:0]  o_count,
    input logic        o_is_empty,
    input logic [31:0] o_front_word
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_count) && $stable(o_hit))
        else $error("result changed while stalled");
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("no result after accepted transaction");
    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_front_word == 32'd0 && o_count == 5'd0)
        else $error("empty list shows data");
    a_status_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> !o_hit)
        else $error("hit with error status");
endmodule

bind bounded_deque_with_remove bdq_checker u_bdq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_hit(o_hit), .o_status(o_status),
    .o_count(o_count), .o_is_empty(o_is_empty), .o_front_word(o_front_word)
);
